// ===== sv/ecwt_pkg.sv =====
package ecwt_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int PEAK_W  = 12;
    localparam int TIME_W  = 24;
    localparam int POS_W   = 16;
    localparam int RAD_W   = 15;
    localparam int RATIO_W = 8;
    localparam int SUM_W   = 20;
    localparam int USED_W  = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // peak squared, and the signed weight-times-time product
    localparam int W_W  = 2 * PEAK_W;
    localparam int WT_W = W_W + TIME_W;

    localparam logic [USED_W-1:0] USED_MAX = '1;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_FID_RADIUS  = 3'd2,
        REG_REF_LOW     = 3'd3,
        REG_REF_HIGH    = 3'd4,
        REG_CHAN_MIN    = 3'd5,
        REG_CONTAIN     = 3'd6,
        REG_LG_THRESH   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        RSN_PASS       = 3'd0,
        RSN_CHAMBER    = 3'd1,
        RSN_REF_WINDOW = 3'd2,
        RSN_FIDUCIAL   = 3'd3,
        RSN_FEW_CHAN   = 3'd4,
        RSN_CONTAIN    = 3'd5
    } reason_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic [RAD_W-1:0]        fiducial_radius;
        logic [PEAK_W-1:0]       ref_low;
        logic [PEAK_W-1:0]       ref_high;
        logic [PEAK_W-1:0]       channel_min_peak;
        logic [RATIO_W-1:0]      contain_ratio;
        logic [SUM_W-1:0]        lg_sum_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_x:         16'sd0,
        center_y:         16'sd0,
        fiducial_radius:  15'd3000,
        ref_low:          12'd200,
        ref_high:         12'd750,
        channel_min_peak: 12'd20,
        contain_ratio:    8'd77,
        lg_sum_threshold: 20'd0
    };

    // cut results gathered by the front end, resolved to a reason in the back end
    typedef struct packed {
        logic chamber_bad;
        logic ref_bad;
        logic fid_bad;
        logic contain_bad;
    } cut_flags_t;

endpackage

// ===== sv/ecwt_in_if.sv =====
interface ecwt_in_if;
    import ecwt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [PEAK_W-1:0]        chan_peak;
    logic signed [TIME_W-1:0] chan_time;
    logic                     time_ok;
    logic                     last_channel;
    logic signed [POS_W-1:0]  track_x;
    logic signed [POS_W-1:0]  track_y;
    logic                     chamber_ok;
    logic [PEAK_W-1:0]        ref_peak;
    logic [SUM_W-1:0]         lg_sum;
    logic [SUM_W-1:0]         pb_sum;

    modport source (
        output valid, chan_peak, chan_time, time_ok, last_channel, track_x, track_y,
               chamber_ok, ref_peak, lg_sum, pb_sum,
        input  ready
    );

    modport sink (
        input  valid, chan_peak, chan_time, time_ok, last_channel, track_x, track_y,
               chamber_ok, ref_peak, lg_sum, pb_sum,
        output ready
    );

endinterface

// ===== sv/ecwt_out_if.sv =====
interface ecwt_out_if;
    import ecwt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [TIME_W-1:0] combo_time;
    logic [USED_W-1:0]        used_channels;
    logic [2:0]               reject_reason;

    modport source (
        output valid, accepted, combo_time, used_channels, reject_reason,
        input  ready
    );

    modport sink (
        input  valid, accepted, combo_time, used_channels, reject_reason,
        output ready
    );

endinterface

// ===== sv/ecwt_regs.sv =====
module ecwt_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ecwt_pkg::ADDR_W-1:0] paddr,
    input  logic [ecwt_pkg::DATA_W-1:0] pwdata,
    output logic [ecwt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ecwt_pkg::cfg_t             cfg
);
    import ecwt_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CENTER_X:   cfg_next.center_x         = pwdata[POS_W-1:0];
                REG_CENTER_Y:   cfg_next.center_y         = pwdata[POS_W-1:0];
                REG_FID_RADIUS: cfg_next.fiducial_radius  = pwdata[RAD_W-1:0];
                REG_REF_LOW:    cfg_next.ref_low          = pwdata[PEAK_W-1:0];
                REG_REF_HIGH:   cfg_next.ref_high         = pwdata[PEAK_W-1:0];
                REG_CHAN_MIN:   cfg_next.channel_min_peak = pwdata[PEAK_W-1:0];
                REG_CONTAIN:    cfg_next.contain_ratio    = pwdata[RATIO_W-1:0];
                REG_LG_THRESH:  cfg_next.lg_sum_threshold = pwdata[SUM_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:   prdata = DATA_W'(unsigned'(cfg_reg.center_x));
            REG_CENTER_Y:   prdata = DATA_W'(unsigned'(cfg_reg.center_y));
            REG_FID_RADIUS: prdata = DATA_W'(cfg_reg.fiducial_radius);
            REG_REF_LOW:    prdata = DATA_W'(cfg_reg.ref_low);
            REG_REF_HIGH:   prdata = DATA_W'(cfg_reg.ref_high);
            REG_CHAN_MIN:   prdata = DATA_W'(cfg_reg.channel_min_peak);
            REG_CONTAIN:    prdata = DATA_W'(cfg_reg.contain_ratio);
            REG_LG_THRESH:  prdata = DATA_W'(cfg_reg.lg_sum_threshold);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/ecwt_front.sv =====
module ecwt_front #(
    parameter int NUM_CHANNELS = ecwt_pkg::NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = ecwt_pkg::QUEUE_DEPTH_DEF,
    localparam int VCNT_W = $clog2(NUM_CHANNELS + 1),
    localparam int WSUM_W = ecwt_pkg::W_W + $clog2(NUM_CHANNELS),
    localparam int TSUM_W = ecwt_pkg::WT_W + $clog2(NUM_CHANNELS),
    localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ecwt_pkg::cfg_t            cfg,
    ecwt_in_if.sink                   in_ch,
    input  logic [LVL_W-1:0]          queue_level,
    output logic                      job_valid,
    output ecwt_pkg::cut_flags_t      job_flags,
    output logic [VCNT_W-1:0]         job_vcnt,
    output logic [WSUM_W-1:0]         job_wsum,
    output logic signed [TSUM_W-1:0]  job_tsum
);
    import ecwt_pkg::*;

    localparam int D_W   = POS_W + 1;
    localparam int D2_W  = 2 * D_W;
    localparam int R2_W  = 2 * RAD_W;
    localparam int CR_W  = RATIO_W + SUM_W;
    localparam int CNT_W = LVL_W + 2;

    logic accept;

    // channel position within the event
    logic [VCNT_W-1:0] chan_idx_reg, chan_idx_next;
    logic              in_range;

    // stage 1: qualify, offsets from the beam center, reference window
    logic                     s1_v_reg;
    logic                     s1_last_reg, s1_use_reg;
    logic [PEAK_W-1:0]        s1_peak_reg;
    logic signed [TIME_W-1:0] s1_time_reg;
    logic signed [D_W-1:0]    s1_dx_reg, s1_dy_reg;
    logic                     s1_chamber_bad_reg, s1_ref_bad_reg;
    logic [SUM_W-1:0]         s1_lg_reg, s1_pb_reg;

    // stage 2: squares and the containment product
    logic                     s2_v_reg;
    logic                     s2_last_reg, s2_use_reg;
    logic [W_W-1:0]           s2_w_reg;
    logic signed [TIME_W-1:0] s2_time_reg;
    logic [D2_W-1:0]          s2_dx2_reg, s2_dy2_reg;
    logic [R2_W-1:0]          s2_r2_reg;
    logic [CR_W-1:0]          s2_crlg_reg;
    logic                     s2_chamber_bad_reg, s2_ref_bad_reg;
    logic [SUM_W-1:0]         s2_lg_reg, s2_pb_reg;

    // stage 3: weighted time and cut compares
    logic                     s3_v_reg;
    logic                     s3_last_reg, s3_use_reg;
    logic [W_W-1:0]           s3_w_reg;
    logic signed [WT_W-1:0]   s3_wt_reg;
    cut_flags_t               s3_flags_reg;

    logic signed [D2_W-1:0]   dx2_full, dy2_full;
    logic signed [WT_W:0]     wt_full;
    logic [D2_W:0]            d2_sum;

    // event accumulators
    logic [WSUM_W-1:0]        wsum_reg, wsum_next, wsum_add;
    logic signed [TSUM_W-1:0] tsum_reg, tsum_next, tsum_add;
    logic [VCNT_W-1:0]        vcnt_reg, vcnt_next, vcnt_add;

    logic [CNT_W-1:0]         lasts_in_flight;
    logic [CNT_W-1:0]         committed;

    // hold input until every event in flight is sure of a queue slot
    assign lasts_in_flight = CNT_W'(s1_v_reg && s1_last_reg) + CNT_W'(s2_v_reg && s2_last_reg)
                           + CNT_W'(s3_v_reg && s3_last_reg);
    assign committed   = CNT_W'(queue_level) + lasts_in_flight;
    assign in_ch.ready = (committed < CNT_W'(QUEUE_DEPTH));
    assign accept      = in_ch.valid && in_ch.ready;

    assign in_range = (chan_idx_reg < VCNT_W'(NUM_CHANNELS));

    always_comb
    begin
        chan_idx_next = chan_idx_reg;
        if (accept)
        begin
            if (in_ch.last_channel)
                chan_idx_next = '0;
            else if (in_range)
                chan_idx_next = chan_idx_reg + VCNT_W'(1);
        end
    end

    assign dx2_full = D2_W'(s1_dx_reg) * D2_W'(s1_dx_reg);
    assign dy2_full = D2_W'(s1_dy_reg) * D2_W'(s1_dy_reg);
    assign wt_full  = (WT_W + 1)'($signed({1'b0, s2_w_reg})) * (WT_W + 1)'(s2_time_reg);
    assign d2_sum   = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};

    assign wsum_add = wsum_reg + WSUM_W'(s3_w_reg);
    assign tsum_add = tsum_reg + TSUM_W'(s3_wt_reg);
    assign vcnt_add = vcnt_reg + VCNT_W'(s3_use_reg);

    always_comb
    begin
        wsum_next = wsum_reg;
        tsum_next = tsum_reg;
        vcnt_next = vcnt_reg;
        if (s3_v_reg)
        begin
            if (s3_last_reg)
            begin
                wsum_next = '0;
                tsum_next = '0;
                vcnt_next = '0;
            end
            else
            begin
                wsum_next = wsum_add;
                tsum_next = tsum_add;
                vcnt_next = vcnt_add;
            end
        end
    end

    assign job_valid = s3_v_reg && s3_last_reg;
    assign job_flags = s3_flags_reg;
    assign job_wsum  = wsum_add;
    assign job_tsum  = tsum_add;
    assign job_vcnt  = vcnt_add;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_idx_reg <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            wsum_reg     <= '0;
            tsum_reg     <= '0;
            vcnt_reg     <= '0;
        end
        else
        begin
            chan_idx_reg <= chan_idx_next;
            s1_v_reg     <= accept;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            wsum_reg     <= wsum_next;
            tsum_reg     <= tsum_next;
            vcnt_reg     <= vcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg        <= in_ch.last_channel;
        s1_use_reg         <= in_range && in_ch.time_ok
                              && (in_ch.chan_peak >= cfg.channel_min_peak);
        s1_peak_reg        <= in_ch.chan_peak;
        s1_time_reg        <= in_ch.chan_time;
        s1_dx_reg          <= D_W'(in_ch.track_x) - D_W'(cfg.center_x);
        s1_dy_reg          <= D_W'(in_ch.track_y) - D_W'(cfg.center_y);
        s1_chamber_bad_reg <= !in_ch.chamber_ok;
        s1_ref_bad_reg     <= (in_ch.ref_peak < cfg.ref_low) || (in_ch.ref_peak > cfg.ref_high);
        s1_lg_reg          <= in_ch.lg_sum;
        s1_pb_reg          <= in_ch.pb_sum;

        s2_last_reg        <= s1_last_reg;
        s2_use_reg         <= s1_use_reg;
        s2_w_reg           <= s1_use_reg ? W_W'(s1_peak_reg) * W_W'(s1_peak_reg) : '0;
        s2_time_reg        <= s1_time_reg;
        s2_dx2_reg         <= unsigned'(dx2_full);
        s2_dy2_reg         <= unsigned'(dy2_full);
        s2_r2_reg          <= R2_W'(cfg.fiducial_radius) * R2_W'(cfg.fiducial_radius);
        s2_crlg_reg        <= CR_W'(cfg.contain_ratio) * CR_W'(s1_lg_reg);
        s2_chamber_bad_reg <= s1_chamber_bad_reg;
        s2_ref_bad_reg     <= s1_ref_bad_reg;
        s2_lg_reg          <= s1_lg_reg;
        s2_pb_reg          <= s1_pb_reg;

        s3_last_reg              <= s2_last_reg;
        s3_use_reg               <= s2_use_reg;
        s3_w_reg                 <= s2_w_reg;
        s3_wt_reg                <= wt_full[WT_W-1:0];
        s3_flags_reg.chamber_bad <= s2_chamber_bad_reg;
        s3_flags_reg.ref_bad     <= s2_ref_bad_reg;
        s3_flags_reg.fid_bad     <= (d2_sum >= (D2_W + 1)'(s2_r2_reg));
        s3_flags_reg.contain_bad <= (s2_lg_reg > cfg.lg_sum_threshold)
                                    && ({s2_pb_reg, 8'd0} >= s2_crlg_reg);
    end

endmodule

// ===== sv/ecwt_fifo.sv =====
module ecwt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ecwt_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LVL_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty,
    output logic [LVL_W-1:0] level
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            level_next = level_reg + LVL_W'(1);
        else if (pop && !push)
            level_next = level_reg - LVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== sv/ecwt_back.sv =====
module ecwt_back #(
    parameter int NUM_CHANNELS = ecwt_pkg::NUM_CHANNELS_DEF,
    localparam int VCNT_W = $clog2(NUM_CHANNELS + 1),
    localparam int WSUM_W = ecwt_pkg::W_W + $clog2(NUM_CHANNELS),
    localparam int TSUM_W = ecwt_pkg::WT_W + $clog2(NUM_CHANNELS)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_empty,
    input  ecwt_pkg::cut_flags_t      job_flags,
    input  logic [VCNT_W-1:0]         job_vcnt,
    input  logic [WSUM_W-1:0]         job_wsum,
    input  logic signed [TSUM_W-1:0]  job_tsum,
    output logic                      job_pop,
    ecwt_out_if.source                out_ch
);
    import ecwt_pkg::*;

    localparam int Q_W    = TIME_W;
    localparam int STEP_W = $clog2(Q_W);
    localparam int DVD_W  = TSUM_W + 1;

    back_state_t state_reg, state_next;

    logic                 neg_reg, neg_next;
    logic [TSUM_W-1:0]    mag_reg, mag_next;
    logic [WSUM_W-1:0]    den_reg, den_next;
    logic [WSUM_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]       dvd_reg, dvd_next;
    logic [Q_W-1:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [VCNT_W-1:0]    vcnt_reg, vcnt_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     accepted_reg, accepted_next;
    logic signed [TIME_W-1:0] combo_reg, combo_next;
    logic [USED_W-1:0]        used_reg, used_next;
    reason_t                  reason_reg, reason_next;

    reason_t              job_reason;
    logic                 out_free;
    logic [DVD_W-1:0]     rounded;
    logic [WSUM_W:0]      trial;
    logic                 fits;
    logic [7:0]           vcnt_wide;
    logic [USED_W-1:0]    job_used;
    logic [USED_W-1:0]    hold_used;

    assign out_free = !out_valid_reg || out_ch.ready;

    // first failing cut wins
    always_comb
    begin
        if (job_flags.chamber_bad)
            job_reason = RSN_CHAMBER;
        else if (job_flags.ref_bad)
            job_reason = RSN_REF_WINDOW;
        else if (job_flags.fid_bad)
            job_reason = RSN_FIDUCIAL;
        else if ((job_vcnt < VCNT_W'(2)) || (job_wsum == '0))
            job_reason = RSN_FEW_CHAN;
        else if (job_flags.contain_bad)
            job_reason = RSN_CONTAIN;
        else
            job_reason = RSN_PASS;
    end

    assign vcnt_wide = 8'(job_vcnt);
    assign job_used  = (vcnt_wide > 8'(USED_MAX)) ? USED_MAX : USED_W'(vcnt_wide);
    assign hold_used = (8'(vcnt_reg) > 8'(USED_MAX)) ? USED_MAX : USED_W'(8'(vcnt_reg));

    // round half away from zero: add half the divisor to the magnitude
    assign rounded = {1'b0, mag_reg} + DVD_W'(den_reg >> 1);
    assign trial   = {rem_reg, dvd_reg[Q_W-1]};
    assign fits    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        vcnt_next      = vcnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        accepted_next  = accepted_reg;
        combo_next     = combo_reg;
        used_next      = used_reg;
        reason_next    = reason_reg;
        job_pop        = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    if (job_reason != RSN_PASS)
                    begin
                        if (out_free)
                        begin
                            job_pop        = 1'b1;
                            out_valid_next = 1'b1;
                            accepted_next  = 1'b0;
                            combo_next     = '0;
                            used_next      = job_used;
                            reason_next    = job_reason;
                        end
                    end
                    else
                    begin
                        job_pop    = 1'b1;
                        neg_next   = job_tsum[TSUM_W-1];
                        mag_next   = job_tsum[TSUM_W-1] ? unsigned'(-job_tsum)
                                                        : unsigned'(job_tsum);
                        den_next   = job_wsum;
                        vcnt_next  = job_vcnt;
                        state_next = BK_PREP;
                    end
                end
            end

            BK_PREP:
            begin
                rem_next   = WSUM_W'(rounded >> Q_W);
                dvd_next   = rounded[Q_W-1:0];
                quo_next   = '0;
                step_next  = '0;
                state_next = BK_DIV;
            end

            BK_DIV:
            begin
                // one quotient bit per cycle
                rem_next  = fits ? WSUM_W'(trial - {1'b0, den_reg}) : trial[WSUM_W-1:0];
                quo_next  = {quo_reg[Q_W-2:0], fits};
                dvd_next  = {dvd_reg[Q_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(Q_W - 1))
                    state_next = BK_DONE;
            end

            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = 1'b1;
                    combo_next     = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);
                    used_next      = hold_used;
                    reason_next    = RSN_PASS;
                    state_next     = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.accepted      = accepted_reg;
    assign out_ch.combo_time    = combo_reg;
    assign out_ch.used_channels = used_reg;
    assign out_ch.reject_reason = reason_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        vcnt_reg     <= vcnt_next;
        accepted_reg <= accepted_next;
        combo_reg    <= combo_next;
        used_reg     <= used_next;
        reason_reg   <= reason_next;
    end

endmodule

// ===== sv/event_cut_weighted_time_combiner.sv =====
// Event cut and amplitude-squared weighted time combiner.
//
// in_ch carries one detector channel per beat: peak, time, timing flag and
// a last-channel mark; the last beat of an event also carries the track,
// chamber, reference peak and calorimeter sums. out_ch carries one result
// beat per event: accept flag, weighted mean time, used channel count and
// the first failing cut. The APB port holds the cut settings; write it only
// while no event is in flight.
// Throughput: one channel beat per cycle while the event queue has room.
// Each event closes into a four-entry queue; the back end takes a passing
// event through the bit-serial mean divider (one quotient bit a cycle over
// 24 bits) and a rejected one straight to the output register. Events
// shorter than the divide time therefore back up the queue and hold
// in_ch.ready low. A closed event passes front-end stages s1 to s3 and the
// queue; a passing one then steps through the PREP, DIV and DONE states.
// Reset clears the accumulators, queue and output, and loads the default
// cut settings. When the receiver stalls, the output beat holds, the
// divider finishes and waits, and the queue then fills and stalls in_ch.
module event_cut_weighted_time_combiner #(
    parameter int NUM_CHANNELS = ecwt_pkg::NUM_CHANNELS_DEF,
    parameter int QUEUE_DEPTH  = ecwt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecwt_pkg::ADDR_W-1:0] paddr,
    input  logic [ecwt_pkg::DATA_W-1:0] pwdata,
    output logic [ecwt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    ecwt_in_if.sink                     in_ch,
    ecwt_out_if.source                  out_ch
);
    import ecwt_pkg::*;

    localparam int VCNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int WSUM_W = W_W + $clog2(NUM_CHANNELS);
    localparam int TSUM_W = WT_W + $clog2(NUM_CHANNELS);
    localparam int FLAG_W = $bits(cut_flags_t);
    localparam int JOB_W  = FLAG_W + VCNT_W + WSUM_W + TSUM_W;
    localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);

    cfg_t cfg;

    // front end to queue
    logic                     push;
    cut_flags_t               push_flags;
    logic [VCNT_W-1:0]        push_vcnt;
    logic [WSUM_W-1:0]        push_wsum;
    logic signed [TSUM_W-1:0] push_tsum;

    // queue to back end
    logic [JOB_W-1:0]         job_din, job_dout;
    logic                     job_empty, job_pop;
    logic [LVL_W-1:0]         job_level;
    cut_flags_t               head_flags;
    logic [VCNT_W-1:0]        head_vcnt;
    logic [WSUM_W-1:0]        head_wsum;
    logic signed [TSUM_W-1:0] head_tsum;

    ecwt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // accumulate channels and evaluate the cuts, one beat per cycle while the queue has room
    ecwt_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_ch       (in_ch),
        .queue_level (job_level),
        .job_valid   (push),
        .job_flags   (push_flags),
        .job_vcnt    (push_vcnt),
        .job_wsum    (push_wsum),
        .job_tsum    (push_tsum)
    );

    assign job_din = {push_flags, push_vcnt, push_wsum, push_tsum};

    // closed events wait here for the divider
    ecwt_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_din),
        .pop   (job_pop),
        .dout  (job_dout),
        .empty (job_empty),
        .level (job_level)
    );

    assign {head_flags, head_vcnt, head_wsum, head_tsum} = job_dout;

    // resolve the reject reason, divide out the mean, drive the result beat
    ecwt_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_flags (head_flags),
        .job_vcnt  (head_vcnt),
        .job_wsum  (head_wsum),
        .job_tsum  (head_tsum),
        .job_pop   (job_pop),
        .out_ch    (out_ch)
    );

endmodule

// ===== tb/sv/event_cut_weighted_time_combiner_tb.sv =====
`timescale 1ns / 1ps

module event_cut_weighted_time_combiner_tb;
    import ecwt_pkg::*;

    localparam int NUM_CH     = NUM_CHANNELS_DEF;
    // cycles to let the divider and output stage settle before a register write
    localparam int SETTLE_CYC = 40;
    localparam int HOLD_CYC   = 300;

    // one channel beat as it goes onto in_ch
    typedef struct {
        logic [PEAK_W-1:0]        peak;
        logic signed [TIME_W-1:0] ctime;
        logic                     tok;
        logic                     last;
        logic signed [POS_W-1:0]  tx;
        logic signed [POS_W-1:0]  ty;
        logic                     chamber;
        logic [PEAK_W-1:0]        rpeak;
        logic [SUM_W-1:0]         lg;
        logic [SUM_W-1:0]         pb;
    } chan_beat_t;

    // one event result as it should come out of out_ch
    typedef struct {
        logic                     accepted;
        logic signed [TIME_W-1:0] combo_time;
        logic [USED_W-1:0]        used_channels;
        reason_t                  reason;
    } event_result_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ecwt_in_if  in_ch ();
    ecwt_out_if out_ch ();

    event_cut_weighted_time_combiner i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Shadow of the cut settings and of the event accumulators.
    cfg_t            model_cfg  = CFG_RESET;
    longint          acc_weight = 0;
    longint          acc_wtime  = 0;
    int              acc_count  = 0;
    int              acc_index  = 0;

    event_result_t   pending_results[$];
    int              errors_seen = 0;
    int              items_sent  = 0;
    logic            steady      = 1'b0;   // no idling on either side while set
    logic            out_hold    = 1'b0;   // long receiver hold-off in progress
    event            stall_trig;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: fold one accepted channel beat into the event sums and,
    // on the last channel, resolve the cuts and the rounded weighted mean.
    // ------------------------------------------------------------------
    function automatic bit combine_channel(input chan_beat_t b, output event_result_t r);
        longint  w;
        longint  dx;
        longint  dy;
        longint  d2;
        longint  r2;
        longint  mag;
        longint  q;
        longint  mean;
        reason_t why;
        // channels past the channel count of an event are dropped, but
        // a last mark on one of them still closes the event
        if (acc_index < NUM_CH)
        begin
            if (b.peak >= model_cfg.channel_min_peak && b.tok)
            begin
                w = longint'(b.peak) * longint'(b.peak);
                acc_weight += w;
                acc_wtime  += w * longint'(b.ctime);
                acc_count++;
            end
            acc_index++;
        end
        if (!b.last)
            return 1'b0;

        dx = longint'(b.tx) - longint'($signed(model_cfg.center_x));
        dy = longint'(b.ty) - longint'($signed(model_cfg.center_y));
        d2 = dx * dx + dy * dy;
        r2 = longint'(model_cfg.fiducial_radius) * longint'(model_cfg.fiducial_radius);

        // first failing cut wins
        if (!b.chamber)
            why = RSN_CHAMBER;
        else if (b.rpeak < model_cfg.ref_low || b.rpeak > model_cfg.ref_high)
            why = RSN_REF_WINDOW;
        else if (d2 >= r2)
            why = RSN_FIDUCIAL;
        else if (acc_count < 2 || acc_weight == 0)
            why = RSN_FEW_CHAN;
        else if (b.lg > model_cfg.lg_sum_threshold &&
                 longint'(b.pb) * 256 >= longint'(model_cfg.contain_ratio) * longint'(b.lg))
            why = RSN_CONTAIN;
        else
            why = RSN_PASS;

        // round half away from zero on the magnitude
        mean = 0;
        if (why == RSN_PASS)
        begin
            mag  = (acc_wtime < 0) ? -acc_wtime : acc_wtime;
            q    = (mag + acc_weight / 2) / acc_weight;
            mean = (acc_wtime < 0) ? -q : q;
        end

        r.accepted      = (why == RSN_PASS);
        r.combo_time    = mean[TIME_W-1:0];
        r.used_channels = (acc_count > 15) ? USED_MAX : acc_count[USED_W-1:0];
        r.reason        = why;

        acc_weight = 0;
        acc_wtime  = 0;
        acc_count  = 0;
        acc_index  = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic chan_beat_t mk_chan(int peak, int ctime, bit tok);
        chan_beat_t b;
        // event fields are ignored off the last channel, so fill them with noise
        b.peak    = PEAK_W'(peak);
        b.ctime   = TIME_W'(ctime);
        b.tok     = tok;
        b.last    = 1'b0;
        b.tx      = POS_W'($urandom);
        b.ty      = POS_W'($urandom);
        b.chamber = 1'($urandom);
        b.rpeak   = PEAK_W'($urandom);
        b.lg      = SUM_W'($urandom);
        b.pb      = SUM_W'($urandom);
        return b;
    endfunction

    function automatic chan_beat_t mk_last(int peak, int ctime, bit tok, int tx, int ty,
                                           bit chamber, int rpeak, int lg, int pb);
        chan_beat_t b;
        b         = mk_chan(peak, ctime, tok);
        b.last    = 1'b1;
        b.tx      = POS_W'(tx);
        b.ty      = POS_W'(ty);
        b.chamber = chamber;
        b.rpeak   = PEAK_W'(rpeak);
        b.lg      = SUM_W'(lg);
        b.pb      = SUM_W'(pb);
        return b;
    endfunction

    function automatic chan_beat_t random_channel(bit good);
        chan_beat_t b;
        int         t;
        // keep most times near zero, but sweep the full range now and then
        t = ($urandom_range(99) < 75) ? int'($urandom_range(20000)) - 10000 : int'($urandom);
        if (good)
            b = mk_chan(int'($urandom_range(4095, model_cfg.channel_min_peak)), t,
                        $urandom_range(99) < 90);
        else
            b = mk_chan(int'($urandom), t, 1'($urandom));
        return b;
    endfunction

    function automatic logic signed [POS_W-1:0] near_center(int c, int half);
        int v;
        v = c + int'($urandom_range(2 * half)) - half;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[POS_W-1:0];
    endfunction

    // Fill the event fields of a last channel so that most cuts pass.
    function automatic chan_beat_t close_event(chan_beat_t b);
        int half;
        int cap;
        half      = int'(model_cfg.fiducial_radius) / 2;
        b.chamber = $urandom_range(99) < 95;
        if (model_cfg.ref_low <= model_cfg.ref_high)
            b.rpeak = PEAK_W'($urandom_range(model_cfg.ref_high, model_cfg.ref_low));
        b.tx = near_center(int'($signed(model_cfg.center_x)), half);
        b.ty = near_center(int'($signed(model_cfg.center_y)), half);
        cap  = (int'(model_cfg.contain_ratio) * int'(b.lg)) / 256;
        if ($urandom_range(99) < 80)
            b.pb = SUM_W'($urandom_range(cap));
        return b;
    endfunction

    function automatic int pick_event_length();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 1;
        else if (r < 12)
            return $urandom_range(NUM_CH + 4, NUM_CH + 1);
        return $urandom_range(NUM_CH, 2);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.center_x         = POS_W'(int'($urandom_range(40000)) - 20000);
        c.center_y         = POS_W'(int'($urandom_range(40000)) - 20000);
        c.fiducial_radius  = RAD_W'($urandom_range(32767, 500));
        c.ref_low          = PEAK_W'($urandom_range(1000));
        c.ref_high         = PEAK_W'($urandom_range(4095, c.ref_low));
        c.channel_min_peak = PEAK_W'($urandom_range(300));
        c.contain_ratio    = RATIO_W'($urandom);
        c.lg_sum_threshold = SUM_W'(($urandom_range(1) != 0) ? $urandom_range(1000) : $urandom);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Channel sender: idle at random, hold the beat until it is taken,
    // then predict. Valid stays high into the next call.
    // ------------------------------------------------------------------
    task automatic send_beat(chan_beat_t b);
        event_result_t r;
        if (!steady && $urandom_range(99) < 15)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.chan_peak    <= b.peak;
        in_ch.chan_time    <= b.ctime;
        in_ch.time_ok      <= b.tok;
        in_ch.last_channel <= b.last;
        in_ch.track_x      <= b.tx;
        in_ch.track_y      <= b.ty;
        in_ch.chamber_ok   <= b.chamber;
        in_ch.ref_peak     <= b.rpeak;
        in_ch.lg_sum       <= b.lg;
        in_ch.pb_sum       <= b.pb;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (combine_channel(b, r))
            pending_results.insert(pending_results.size(), r);
    endtask

    task automatic send_event(int n, bit good);
        chan_beat_t b;
        for (int k = 0; k < n; k++)
        begin
            b = random_channel(good);
            if (k == n - 1)
            begin
                b.last = 1'b1;
                if (good)
                    b = close_event(b);
            end
            send_beat(b);
        end
    endtask

    // Drop valid, wait for every pending result, then let the back end settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // APB write: setup phase, then access phase; psel and penable drop after.
    task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_CENTER_X:   model_cfg.center_x         = value[POS_W-1:0];
            REG_CENTER_Y:   model_cfg.center_y         = value[POS_W-1:0];
            REG_FID_RADIUS: model_cfg.fiducial_radius  = value[RAD_W-1:0];
            REG_REF_LOW:    model_cfg.ref_low          = value[PEAK_W-1:0];
            REG_REF_HIGH:   model_cfg.ref_high         = value[PEAK_W-1:0];
            REG_CHAN_MIN:   model_cfg.channel_min_peak = value[PEAK_W-1:0];
            REG_CONTAIN:    model_cfg.contain_ratio    = value[RATIO_W-1:0];
            REG_LG_THRESH:  model_cfg.lg_sum_threshold = value[SUM_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(cfg_t c);
        cfg_write(REG_CENTER_X,   DATA_W'(c.center_x));
        cfg_write(REG_CENTER_Y,   DATA_W'(c.center_y));
        cfg_write(REG_FID_RADIUS, DATA_W'(c.fiducial_radius));
        cfg_write(REG_REF_LOW,    DATA_W'(c.ref_low));
        cfg_write(REG_REF_HIGH,   DATA_W'(c.ref_high));
        cfg_write(REG_CHAN_MIN,   DATA_W'(c.channel_min_peak));
        cfg_write(REG_CONTAIN,    DATA_W'(c.contain_ratio));
        cfg_write(REG_LG_THRESH,  DATA_W'(c.lg_sum_threshold));
    endtask

    task automatic random_phase(int n_items);
        int start;
        start = items_sent;
        // mostly well-formed events with random content, the rest pure noise
        while (items_sent - start < n_items)
            send_event(pick_event_length(), $urandom_range(99) < 80);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every cut with the reset settings, its boundaries, and the rounding ties.
    task automatic test_cut_order();
        // mean of 0 and 1 at equal weight: tie rounds up; fiducial and
        // containment just inside, reference at its lower bound
        send_beat(mk_chan(100, 0, 1));
        send_beat(mk_last(100, 1, 1, 2999, 0, 1, 200, 1000, 300));
        // negative tie rounds away from zero; zero lg sum skips containment
        send_beat(mk_chan(100, 0, 1));
        send_beat(mk_last(100, -1, 1, 0, 0, 1, 750, 0, 1048575));
        // chamber failure outranks everything else; extreme peaks and times
        send_beat(mk_chan(4095, 8388607, 1));
        send_beat(mk_last(4095, -8388608, 1, -32768, 32767, 0, 0, 1048575, 1048575));
        // reference window, one below and one above
        send_beat(mk_last(500, 10, 1, 0, 0, 1, 199, 0, 0));
        send_beat(mk_last(500, 10, 1, 0, 0, 1, 751, 0, 0));
        // track exactly on the fiducial circle
        send_beat(mk_chan(500, 100, 1));
        send_beat(mk_last(500, 200, 1, 0, -3000, 1, 400, 0, 0));
        // one channel under the minimum peak, one with failed timing
        send_beat(mk_chan(19, 50, 1));
        send_beat(mk_chan(4095, 50, 0));
        send_beat(mk_last(20, 60, 1, 0, 0, 1, 400, 0, 0));
        // containment one step over its limit
        send_beat(mk_chan(1000, -500, 1));
        send_beat(mk_last(1000, 700, 1, 0, 0, 1, 400, 1000, 301));
        wait_drained();
    endtask

    // Channels beyond the channel count are dropped; the last mark still closes.
    task automatic test_long_event();
        for (int k = 0; k < NUM_CH; k++)
            send_beat(mk_chan(100 + 100 * k, 1000 * k, 1));
        send_beat(mk_chan(4095, 8388607, 1));
        send_beat(mk_last(4095, -8388608, 1, 0, 0, 1, 400, 0, 0));
        wait_drained();
    endtask

    // Both extreme corners of every register.
    task automatic test_register_extremes();
        cfg_t c;
        c.center_x         = POS_W'(-32768);
        c.center_y         = POS_W'(32767);
        c.fiducial_radius  = RAD_W'(32767);
        c.ref_low          = PEAK_W'(0);
        c.ref_high         = PEAK_W'(4095);
        c.channel_min_peak = PEAK_W'(0);
        c.contain_ratio    = RATIO_W'(255);
        c.lg_sum_threshold = SUM_W'(1048575);
        apply_settings(c);
        // every channel counts but carries zero weight
        send_beat(mk_chan(0, 1234, 1));
        send_beat(mk_last(0, -1234, 1, -32768, 32767, 1, 0, 0, 0));
        random_phase(30);
        wait_drained();

        c.center_x         = POS_W'(32767);
        c.center_y         = POS_W'(-32768);
        c.fiducial_radius  = RAD_W'(0);
        c.ref_low          = PEAK_W'(4095);
        c.ref_high         = PEAK_W'(0);
        c.channel_min_peak = PEAK_W'(4095);
        c.contain_ratio    = RATIO_W'(0);
        c.lg_sum_threshold = SUM_W'(0);
        apply_settings(c);
        random_phase(30);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 3; p++)
        begin
            apply_settings(random_settings());
            random_phase(170);
            wait_drained();
        end
    endtask

    // Full rate on both sides for a whole phase.
    task automatic test_steady_stream();
        steady <= 1'b1;
        apply_settings(random_settings());
        random_phase(150);
        wait_drained();
        steady <= 1'b0;
    endtask

    // Hold the receiver off while short passing events pile into the queue.
    task automatic test_output_hold();
        apply_settings(CFG_RESET);
        -> stall_trig;
        for (int k = 0; k < 12; k++)
            send_event(2, 1'b1);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver ready
    // ------------------------------------------------------------------
    task automatic check_result();
        event_result_t exp;
        if (pending_results.size() == 0)
        begin
            $error("result beat with no event pending");
            errors_seen++;
            return;
        end
        exp = pending_results.pop_front();
        if (out_ch.accepted !== exp.accepted)
        begin
            $error("accepted: expected %0d, got %0d", exp.accepted, out_ch.accepted);
            errors_seen++;
        end
        if (out_ch.combo_time !== exp.combo_time)
        begin
            $error("combo_time: expected %0d, got %0d", exp.combo_time, out_ch.combo_time);
            errors_seen++;
        end
        if (out_ch.used_channels !== exp.used_channels)
        begin
            $error("used_channels: expected %0d, got %0d",
                   exp.used_channels, out_ch.used_channels);
            errors_seen++;
        end
        if (out_ch.reject_reason !== exp.reason)
        begin
            $error("reject_reason: expected %0d, got %0d", exp.reason, out_ch.reject_reason);
            errors_seen++;
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                check_result();
            if (out_hold || (!steady && $urandom_range(99) < 15))
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Count out the long hold-off here, apart from the checker.
    initial
    begin
        forever
        begin
            @(stall_trig);
            out_hold <= 1'b1;
            repeat (HOLD_CYC) @(posedge clk);
            out_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.chan_peak    <= '0;
        in_ch.chan_time    <= '0;
        in_ch.time_ok      <= 1'b0;
        in_ch.last_channel <= 1'b0;
        in_ch.track_x      <= '0;
        in_ch.track_y      <= '0;
        in_ch.chamber_ok   <= 1'b0;
        in_ch.ref_peak     <= '0;
        in_ch.lg_sum       <= '0;
        in_ch.pb_sum       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cut_order();
        test_long_event();
        test_register_extremes();
        test_random_settings();
        test_steady_stream();
        test_output_hold();
        wait_drained();

        if (errors_seen == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
